// ===== hw/rtl/first_fit_heap_allocator_unit_assert.svh =====
// Assertion macros for the first-fit heap allocator.
// Needs nothing else; included by the checker.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_ASSERT_SVH

// clocked assertion with asynchronous active-low reset
`define FFA_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// a signal holds its value while its word waits for ready
`define FFA_ASSERT_HOLD(name, clk, rst_n, vld, rdy, sig, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

// ===== hw/rtl/ffa_pkg.sv =====
// Package for the first-fit heap allocator: sizes, codes, state and entry types.
// No dependencies.
`default_nettype none
package ffa_pkg;
  localparam int unsigned MAX_BLOCKS   = 64;
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned IDX_W        = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W        = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [1:0] {
    K_ALLOC   = 2'd0,
    K_FREE    = 2'd1,
    K_REALLOC = 2'd2,
    K_CALLOC  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NULL    = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_e;

  typedef enum logic {
    CFG_HEAP_BASE  = 1'b0,
    CFG_HEAP_LIMIT = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_MCHK, S_FIT, S_APPEND, S_FIND, S_RLS, S_BRK, S_RESP
  } state_e;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic        free;
  } ent_t;
endpackage
`default_nettype wire

// ===== hw/rtl/ffa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ffa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/first_fit_heap_allocator_unit.sv =====
// First-fit heap allocator top level: sequencer, block table RAM, break register.
// Depends on ffa_pkg and ffa_ram.
//
// channel | dir | handshake          | word
// cfg     | in  | cfg_valid/ready    | cfg_index_i, cfg_data_i
// in      | in  | in_valid/ready     | kind_i, size_i, count_i, address_i
// out     | out | out_valid/ready    | result_address_o, status_o
//
// One request at a time; each table scan reads one RAM entry per cycle over the N
// table entries, N the block count (at most 64).
// Zeroed array allocate first goes through a registered multiply (S_MUL, then S_MCHK).
// Reset empties the table; entries are only read below the block count.
// cfg is always ready. A held result does not stop the next request until it ends.
`default_nettype none
module first_fit_heap_allocator_unit import ffa_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [31:0] size_i,
  input  wire logic [31:0] count_i,
  input  wire logic [31:0] address_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      result_address_o,
  output logic [1:0]       status_o
);
  state_e            state_q, state_d;
  kind_e             kind_q, kind_d;
  logic [31:0]       sz_q, sz_d, cnt_q, cnt_d, addr_q, addr_d;
  logic [63:0]       prod_q, prod_d;
  logic              grow_q, grow_d;
  logic [CNT_W-1:0]  count_q, count_d, scan_q, scan_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]  cmp_idx_q, cmp_idx_d;
  logic [IDX_W-1:0]  tgt_idx_q, tgt_idx_d;
  logic [31:0]       tgt_start_q, tgt_start_d, tgt_size_q, tgt_size_d;
  logic [31:0]       brk_q, brk_d, base_q, limit_q;
  logic [31:0]       res_q, res_d;
  status_e           st_q, st_d;
  logic              out_valid_q, out_valid_d;
  logic [31:0]       out_res_q, out_res_d;
  status_e           out_st_q, out_st_d;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  ent_t              ram_wdata, rd_ent;
  logic [$bits(ent_t)-1:0] ram_rdata;

  logic              rd_en, hit_fit, hit_find, full;
  logic [31:0]       brk_cur;
  logic [33:0]       app_end;
  logic [CNT_W-1:0]  last_cnt, prev_cnt;

  ffa_ram #(.WIDTH($bits(ent_t)), .DEPTH(MAX_BLOCKS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_ent      = ent_t'(ram_rdata);
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign result_address_o = out_res_q;
  assign status_o    = out_st_q;

  assign rd_en    = (scan_q < count_q);
  assign hit_fit  = rd_ent.free && (rd_ent.size >= sz_q);
  assign hit_find = ({1'b0, rd_ent.start} + 33'(HEADER_BYTES)) == {1'b0, addr_q};
  assign full     = (count_q == CNT_W'(MAX_BLOCKS));
  assign brk_cur  = (count_q == '0) ? base_q : brk_q;
  assign app_end  = {2'b00, brk_cur} + 34'(HEADER_BYTES) + {2'b00, sz_q};
  assign last_cnt = count_q - CNT_W'(1);
  assign prev_cnt = count_q - CNT_W'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
      base_q      <= 32'd0;
      limit_q     <= 32'd1048576;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_HEAP_BASE:  base_q  <= cfg_data_i;
          CFG_HEAP_LIMIT: limit_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    sz_q        <= sz_d;
    cnt_q       <= cnt_d;
    addr_q      <= addr_d;
    prod_q      <= prod_d;
    grow_q      <= grow_d;
    scan_q      <= scan_d;
    cmp_idx_q   <= cmp_idx_d;
    tgt_idx_q   <= tgt_idx_d;
    tgt_start_q <= tgt_start_d;
    tgt_size_q  <= tgt_size_d;
    brk_q       <= brk_d;
    res_q       <= res_d;
    st_q        <= st_d;
    out_res_q   <= out_res_d;
    out_st_q    <= out_st_d;
  end

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    sz_d        = sz_q;
    cnt_d       = cnt_q;
    addr_d      = addr_q;
    prod_d      = prod_q;
    grow_d      = grow_q;
    count_d     = count_q;
    scan_d      = scan_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = scan_q[IDX_W-1:0];
    tgt_idx_d   = tgt_idx_q;
    tgt_start_d = tgt_start_q;
    tgt_size_d  = tgt_size_q;
    brk_d       = brk_q;
    res_d       = res_q;
    st_d        = st_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_res_d   = out_res_q;
    out_st_d    = out_st_q;
    ram_we      = 1'b0;
    ram_waddr   = tgt_idx_q;
    ram_wdata   = '{start: tgt_start_q, size: tgt_size_q, free: 1'b1};
    ram_raddr   = scan_q[IDX_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d = kind_e'(kind_i);
          sz_d   = size_i;
          cnt_d  = count_i;
          addr_d = address_i;
          grow_d = 1'b0;
          scan_d = '0;
          res_d  = 32'd0;
          st_d   = ST_OK;
          case (kind_e'(kind_i))
            K_ALLOC: begin
              if (size_i == 32'd0) begin
                st_d = ST_NULL;
                state_d = S_RESP;
              end else begin
                state_d = S_FIT;
              end
            end
            K_FREE: state_d = (address_i == 32'd0) ? S_RESP : S_FIND;
            K_REALLOC: begin
              if (size_i == 32'd0) begin
                st_d = ST_NULL;
                state_d = S_RESP;
              end else if (address_i == 32'd0) begin
                state_d = S_FIT;
              end else begin
                state_d = S_FIND;
              end
            end
            K_CALLOC: state_d = S_MUL;
            default: state_d = S_RESP;
          endcase
        end
      end
      S_MUL: begin
        prod_d  = 64'(cnt_q) * 64'(sz_q);
        state_d = S_MCHK;
      end
      S_MCHK: begin
        if (prod_q[63:32] != 32'd0 || prod_q[31:0] == 32'd0) begin
          st_d = ST_NULL;
          state_d = S_RESP;
        end else begin
          sz_d    = prod_q[31:0];
          scan_d  = '0;
          state_d = S_FIT;
        end
      end
      S_FIT: begin
        if (cmp_vld_q && hit_fit) begin
          ram_we    = 1'b1;
          ram_waddr = cmp_idx_q;
          ram_wdata = '{start: rd_ent.start, size: rd_ent.size, free: 1'b0};
          res_d     = rd_ent.start + 32'(HEADER_BYTES);
          st_d      = ST_OK;
          state_d   = grow_q ? S_RLS : S_RESP;
        end else if (rd_en) begin
          cmp_vld_d = 1'b1;
          scan_d    = scan_q + CNT_W'(1);
        end else if (!cmp_vld_q) begin
          state_d = S_APPEND;
        end
      end
      S_APPEND: begin
        if (full || app_end > {2'b00, limit_q}) begin
          res_d   = 32'd0;
          st_d    = ST_NULL;
          state_d = S_RESP;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = count_q[IDX_W-1:0];
          ram_wdata = '{start: brk_cur, size: sz_q, free: 1'b0};
          count_d   = count_q + CNT_W'(1);
          brk_d     = app_end[31:0];
          res_d     = brk_cur + 32'(HEADER_BYTES);
          st_d      = ST_OK;
          state_d   = grow_q ? S_RLS : S_RESP;
        end
      end
      S_FIND: begin
        if (cmp_vld_q && hit_find) begin
          tgt_idx_d   = cmp_idx_q;
          tgt_start_d = rd_ent.start;
          tgt_size_d  = rd_ent.size;
          if (kind_q == K_FREE) begin
            state_d = S_RLS;
          end else if (rd_ent.size >= sz_q) begin
            res_d   = addr_q;
            state_d = S_RESP;
          end else begin
            grow_d  = 1'b1;
            scan_d  = '0;
            state_d = S_FIT;
          end
        end else if (rd_en) begin
          cmp_vld_d = 1'b1;
          scan_d    = scan_q + CNT_W'(1);
        end else if (!cmp_vld_q) begin
          st_d    = ST_UNKNOWN;
          state_d = S_RESP;
        end
      end
      S_RLS: begin
        if (CNT_W'(tgt_idx_q) == last_cnt) begin
          count_d   = last_cnt;
          ram_raddr = prev_cnt[IDX_W-1:0];
          state_d   = (last_cnt == '0) ? S_RESP : S_BRK;
        end else begin
          ram_we  = 1'b1;
          state_d = S_RESP;
        end
      end
      S_BRK: begin
        brk_d   = rd_ent.start + 32'(HEADER_BYTES) + rd_ent.size;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          out_st_d    = st_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/ffa_chk.sv =====
// Port-level checker for the first-fit heap allocator, bound to the top level.
// Depends on ffa_pkg and first_fit_heap_allocator_unit_assert.svh.
`default_nettype none
`include "first_fit_heap_allocator_unit_assert.svh"
module ffa_chk import ffa_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o,
  input wire logic        cfg_index_i,
  input wire logic [31:0] cfg_data_i,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [1:0]  kind_i,
  input wire logic [31:0] size_i,
  input wire logic [31:0] count_i,
  input wire logic [31:0] address_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] result_address_o,
  input wire logic [1:0]  status_o
);
  `FFA_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "word dropped")
  `FFA_ASSERT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "ready after accept")
  `FFA_ASSERT(a_null_zero, clk_i, rst_ni, out_valid_o && status_o == ST_NULL |-> result_address_o == 32'd0, "null with address")
  `FFA_ASSERT(a_unknown_zero, clk_i, rst_ni, out_valid_o && status_o == ST_UNKNOWN |-> result_address_o == 32'd0, "unknown with address")
  `FFA_ASSERT_HOLD(a_addr_stable, clk_i, rst_ni, out_valid_o, out_ready_i, result_address_o, "word changed")
endmodule

bind first_fit_heap_allocator_unit ffa_chk u_ffa_chk (.*);
`default_nettype wire

// ===== tb/first_fit_heap_allocator_unit_tb.sv =====
// Self-checking testbench for first_fit_heap_allocator_unit: a directed table, then
// random requests over several heap settings, checked by an in-bench block-table predictor.
// Depends on ffa_pkg and the allocator RTL.
`default_nettype none
module first_fit_heap_allocator_unit_tb;
  import ffa_pkg::*;

  typedef struct {
    kind_e       kind;
    logic [31:0] size;
    logic [31:0] count;
    logic [31:0] address;
    bit          typed;
    logic [31:0] want_addr;
    status_e     want_st;
  } req_row_t;

  typedef struct {
    logic [31:0] addr;
    status_e     st;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  cfg_idx_e    cfg_index_i = CFG_HEAP_BASE;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  kind_e       kind_i = K_ALLOC;
  logic [31:0] size_i = '0;
  logic [31:0] count_i = '0;
  logic [31:0] address_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] result_address_o;
  logic [1:0]  status_o;

  first_fit_heap_allocator_unit dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .kind_i, .size_i, .count_i, .address_i,
    .out_valid_o, .out_ready_i, .result_address_o, .status_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // block table mirror
  logic [31:0] tab_start [MAX_BLOCKS];
  logic [31:0] tab_size  [MAX_BLOCKS];
  bit          tab_free  [MAX_BLOCKS];
  int unsigned tab_used;
  logic [31:0] heap_base, heap_limit;

  reply_t      pending_replies[$];
  int          errors = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;

  function automatic logic [63:0] heap_brk();
    if (tab_used == 0) return {32'b0, heap_base};
    return {32'b0, tab_start[tab_used-1]} + HEADER_BYTES + tab_size[tab_used-1];
  endfunction

  function automatic int find_user(logic [31:0] a);
    for (int i = 0; i < tab_used; i++)
      if ({32'b0, tab_start[i]} + HEADER_BYTES == {32'b0, a}) return i;
    return -1;
  endfunction

  function automatic logic [31:0] take_block(logic [31:0] sz);
    logic [63:0] st, en;
    if (sz == 0) return '0;
    for (int i = 0; i < tab_used; i++)
      if (tab_free[i] && tab_size[i] >= sz) begin
        tab_free[i] = 0;
        return tab_start[i] + HEADER_BYTES;
      end
    if (tab_used >= MAX_BLOCKS) return '0;
    st = heap_brk();
    en = st + HEADER_BYTES + sz;
    if (en > {32'b0, heap_limit}) return '0;
    tab_start[tab_used] = st[31:0];
    tab_size[tab_used]  = sz;
    tab_free[tab_used]  = 0;
    tab_used++;
    return st[31:0] + HEADER_BYTES;
  endfunction

  function automatic void give_back(int i);
    logic [63:0] en;
    en = {32'b0, tab_start[i]} + HEADER_BYTES + tab_size[i];
    if (en == heap_brk()) tab_used--;
    else tab_free[i] = 1;
  endfunction

  function automatic reply_t heap_op(kind_e k, logic [31:0] sz, logic [31:0] cnt,
                                     logic [31:0] a);
    reply_t r;
    int idx;
    logic [63:0] prod;
    logic [31:0] got;
    r.addr = '0;
    r.st = ST_OK;
    case (k)
      K_ALLOC: begin
        r.addr = take_block(sz);
        if (r.addr == 0) r.st = ST_NULL;
      end
      K_FREE: begin
        if (a != 0) begin
          idx = find_user(a);
          if (idx < 0) r.st = ST_UNKNOWN;
          else give_back(idx);
        end
      end
      K_REALLOC: begin
        if (sz == 0 || a == 0) begin
          r.addr = take_block(sz);
          if (r.addr == 0) r.st = ST_NULL;
        end else begin
          idx = find_user(a);
          if (idx < 0) r.st = ST_UNKNOWN;
          else if (tab_size[idx] >= sz) r.addr = a;
          else begin
            got = take_block(sz);
            if (got == 0) r.st = ST_NULL;
            else begin
              give_back(idx);
              r.addr = got;
            end
          end
        end
      end
      default: begin
        prod = {32'b0, cnt} * {32'b0, sz};
        if (cnt == 0 || sz == 0 || prod[63:32] != 0) r.st = ST_NULL;
        else begin
          r.addr = take_block(prod[31:0]);
          if (r.addr == 0) r.st = ST_NULL;
        end
      end
    endcase
    return r;
  endfunction

  task automatic send(req_row_t row);
    bit fire;
    reply_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= row.kind;
    size_i     <= row.size;
    count_i    <= row.count;
    address_i  <= row.address;
    do begin
      @(negedge clk_i);
      fire = in_ready_o;
      if (fire) begin
        r = heap_op(row.kind, row.size, row.count, row.address);
        if (row.typed) begin
          r.addr = row.want_addr;
          r.st   = row.want_st;
        end
        pending_replies.push_back(r);
      end
      @(posedge clk_i);
    end while (!fire);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    bit fire;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(negedge clk_i);
      fire = cfg_ready_o;
      if (fire) begin
        if (idx == CFG_HEAP_BASE) heap_base = val;
        else heap_limit = val;
      end
      @(posedge clk_i);
    end while (!fire);
  endtask

  task automatic settle_and_configure(logic [31:0] base, logic [31:0] lim);
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (160) @(posedge clk_i);
    write_reg(CFG_HEAP_BASE, base);
    write_reg(CFG_HEAP_LIMIT, lim);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic req_row_t random_req();
    req_row_t q;
    int pick;
    pick = $urandom_range(99);
    q.kind = pick < 40 ? K_ALLOC : pick < 70 ? K_FREE : pick < 85 ? K_REALLOC : K_CALLOC;
    pick = $urandom_range(99);
    q.size = pick < 80 ? $urandom_range(256, 1) : pick < 90 ? $urandom_range(16) : $urandom;
    q.count = $urandom;
    if (q.kind == K_CALLOC) begin
      q.size = $urandom_range(40);
      if ($urandom_range(9) != 0) q.count = $urandom_range(8);
      else q.size = $urandom;
    end
    pick = $urandom_range(99);
    if (pick < 75 && tab_used > 0)
      q.address = tab_start[$urandom_range(tab_used - 1)] + HEADER_BYTES;
    else if (pick < 85) q.address = '0;
    else q.address = $urandom;
    q.typed = 0;
    q.want_addr = '0;
    q.want_st = ST_OK;
    return q;
  endfunction

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= stall_pct);

  always @(negedge clk_i) begin
    reply_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected word addr=%h status=%0d", $time, result_address_o,
                 status_o);
        errors++;
      end else begin
        w = pending_replies.pop_front();
        if (result_address_o !== w.addr) begin
          $display("%0t: result_address expected %h got %h", $time, w.addr,
                   result_address_o);
          errors++;
        end
        if (status_o !== w.st) begin
          $display("%0t: status expected %0d got %0d", $time, w.st, status_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

  req_row_t opening [19] = '{
    '{K_ALLOC,   32'd0,          32'd0,       32'd0,          1, 32'd0,  ST_NULL},
    '{K_ALLOC,   32'd100,        32'hFFFFFFFF, 32'd0,         1, 32'd16, ST_OK},
    '{K_FREE,    32'd0,          32'd0,       32'd0,          1, 32'd0,  ST_OK},
    '{K_FREE,    32'd0,          32'd0,       32'hFFFFFFFF,   1, 32'd0,  ST_UNKNOWN},
    '{K_CALLOC,  32'h00010000,   32'h00010000, 32'd0,         1, 32'd0,  ST_NULL},
    '{K_CALLOC,  32'd5,          32'd0,       32'd0,          1, 32'd0,  ST_NULL},
    '{K_CALLOC,  32'd1,          32'hFFFFFFFF, 32'd0,         1, 32'd0,  ST_NULL},
    '{K_ALLOC,   32'hFFFFFFFF,   32'd0,       32'd0,          1, 32'd0,  ST_NULL},
    '{K_REALLOC, 32'd0,          32'd0,       32'd16,         1, 32'd0,  ST_NULL},
    '{K_REALLOC, 32'd50,         32'd0,       32'd0,          0, 32'd0,  ST_OK},
    '{K_REALLOC, 32'd50,         32'd0,       32'd16,         1, 32'd16, ST_OK},
    '{K_REALLOC, 32'd500,        32'd0,       32'd16,         0, 32'd0,  ST_OK},
    '{K_REALLOC, 32'd8,          32'd0,       32'h00012345,   1, 32'd0,  ST_UNKNOWN},
    '{K_FREE,    32'd0,          32'd0,       32'd16,         0, 32'd0,  ST_OK},
    '{K_ALLOC,   32'd40,         32'd0,       32'd0,          0, 32'd0,  ST_OK},
    '{K_CALLOC,  32'd7,          32'd3,       32'd0,          0, 32'd0,  ST_OK},
    '{K_FREE,    32'd0,          32'd0,       32'd714,        0, 32'd0,  ST_OK},
    '{K_FREE,    32'd0,          32'd0,       32'd714,        1, 32'd0,  ST_UNKNOWN},
    '{K_REALLOC, 32'hFFFFFFFF,   32'd0,       32'd0,          1, 32'd0,  ST_NULL}
  };

  logic [31:0] phase_base  [5] = '{32'h100, 32'h0, 32'hFFFFFFFF, 32'h40, 32'h0};
  logic [31:0] phase_limit [5] = '{32'h8000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h1000, 32'h0};
  int          phase_idle  [5] = '{0, 58, 0, 17, 0};
  int          phase_stall [5] = '{0, 0, 58, 17, 0};

  initial begin
    tab_used = 0;
    heap_base = '0;
    heap_limit = 32'd1048576;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (opening[i]) send(opening[i]);
    for (int p = 0; p < 5; p++) begin
      settle_and_configure(phase_base[p], phase_limit[p]);
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      repeat (186) send(random_req());
    end
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire
